FILE: sv/aecp_pkg.sv
package aecp_pkg;

    typedef enum logic [2:0] {
        PH_GROUND,
        PH_ESC,
        PH_CSI,
        PH_INT,
        PH_SKIP
    } phase_t;

    typedef enum logic {
        ST_RUN,
        ST_SWEEP
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_GLYPH,
        OP_CR,
        OP_LF,
        OP_SAVE,
        OP_RESTORE,
        OP_UP1,
        OP_DOWN1,
        OP_RIGHT1,
        OP_HOME,
        OP_CLEAR_PARAMS,
        OP_SKIP_PARAM,
        OP_DIGIT_FIRST,
        OP_DIGIT_NEXT,
        OP_STORE,
        OP_DISPATCH,
        OP_SWEEP_BEGIN,
        OP_ATTR
    } op_t;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_GLYPH    = 3'd1;
    localparam logic [2:0] EV_EOF      = 3'd2;
    localparam logic [2:0] EV_BADINTRO = 3'd3;
    localparam logic [2:0] EV_FATAL    = 3'd4;
    localparam logic [2:0] EV_CLEAR    = 3'd5;

    localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_SOFT_CLEAR = 2'd1;
    localparam logic [1:0] CFG_HARD_CLEAR = 2'd2;

    localparam logic [7:0] CH_EOF    = 8'd26;
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_QUERY  = 8'h3f;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_RIGHT  = 8'h43;
    localparam logic [7:0] CH_LEFT   = 8'h44;
    localparam logic [7:0] CH_HOME   = 8'h48;
    localparam logic [7:0] CH_ERASE  = 8'h4a;
    localparam logic [7:0] CH_ERASEL = 8'h4b;
    localparam logic [7:0] CH_SAVE   = 8'h73;
    localparam logic [7:0] CH_REST   = 8'h75;
    localparam logic [7:0] CH_ATTR   = 8'h6d;
    localparam logic [7:0] CH_SETUP  = 8'h68;
    localparam logic [7:0] CH_RESET  = 8'h6c;

    localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;
    localparam logic [2:0] FG_RESET         = 3'd7;
    localparam logic [7:0] WRAP_MODE        = 8'd7;
    localparam logic [7:0] SGR_RESET        = 8'd0;
    localparam logic [7:0] SGR_BOLD         = 8'd1;
    localparam logic [7:0] SGR_NO_BOLD      = 8'd21;
    localparam logic [7:0] SGR_FG_LO        = 8'd30;
    localparam logic [7:0] SGR_FG_HI        = 8'd37;
    localparam logic [7:0] SGR_BG_LO        = 8'd40;
    localparam logic [7:0] SGR_BG_HI        = 8'd47;

    typedef struct packed {
        op_t        op;
        logic       load_out;
        logic [2:0] event_code;
    } cmd_t;

    typedef struct packed {
        logic idx_full;
        logic idx_zero;
        logic p0_is7;
        logic attr_bad;
        logic attr_last;
        logic out_busy;
    } status_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

endpackage

FILE: sv/ansi_escape_cursor_parser_top.sv
// ANSI text parser: one byte per input transfer, exactly one result transfer per byte.
// The final letter of an ESC [ ... m sequence runs the attribute sweep over the
// stored parameters (at most PARAM_SLOTS), one entry per cycle, ending at the first
// unsupported attribute; its result is given when the sweep ends. A new byte is
// taken while the previous result waits, as long as the output register is not
// stalled and no sweep runs. Configuration writes are accepted in every cycle.
module ansi_escape_cursor_parser_top
#(
    parameter int PARAM_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [15:0] write_x,
    output logic [15:0] write_y,
    output logic [7:0]  glyph,
    output logic [2:0]  fore_colour,
    output logic [2:0]  back_colour,
    output logic        bold,
    output logic        soft_clear,
    output logic        hard_clear,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    aecp_pkg::cmd_t    cmd;
    aecp_pkg::status_t status;

    assign cfg_ready = 1'b1;

    aecp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .status    (status),
        .cmd       (cmd)
    );

    aecp_datapath #(.PARAM_SLOTS(PARAM_SLOTS)) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (text_byte),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .write_x     (write_x),
        .write_y     (write_y),
        .glyph       (glyph),
        .fore_colour (fore_colour),
        .back_colour (back_colour),
        .bold        (bold),
        .soft_clear  (soft_clear),
        .hard_clear  (hard_clear)
    );

endmodule

FILE: sv/aecp_ctrl.sv
module aecp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            text_byte,
    input  aecp_pkg::status_t     status,
    output aecp_pkg::cmd_t        cmd
);

    aecp_pkg::phase_t      phase_reg, phase_next;
    aecp_pkg::ctrl_state_t state_reg, state_next;
    logic                  accept;

    assign in_ready = (state_reg == aecp_pkg::ST_RUN) && !status.out_busy;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aecp_pkg::PH_GROUND;
            state_reg <= aecp_pkg::ST_RUN;
        end
        else
        begin
            phase_reg <= phase_next;
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        state_next     = state_reg;
        cmd.op         = aecp_pkg::OP_NONE;
        cmd.load_out   = 1'b0;
        cmd.event_code = aecp_pkg::EV_NONE;
        unique case (state_reg)
            aecp_pkg::ST_RUN:
            begin
                if (accept)
                begin
                    cmd.load_out = 1'b1;
                    unique case (phase_reg)
                        aecp_pkg::PH_ESC:
                        begin
                            if (text_byte == aecp_pkg::CH_LBRACK)
                            begin
                                cmd.op     = aecp_pkg::OP_CLEAR_PARAMS;
                                phase_next = aecp_pkg::PH_CSI;
                            end
                            else
                            begin
                                cmd.event_code = aecp_pkg::EV_BADINTRO;
                                phase_next     = aecp_pkg::PH_GROUND;
                            end
                        end
                        aecp_pkg::PH_CSI:
                        begin
                            phase_next = aecp_pkg::PH_GROUND;
                            if (text_byte == aecp_pkg::CH_SEMI)
                            begin
                                if (status.idx_full)
                                    cmd.event_code = aecp_pkg::EV_FATAL;
                                else
                                begin
                                    cmd.op     = aecp_pkg::OP_SKIP_PARAM;
                                    phase_next = aecp_pkg::PH_CSI;
                                end
                            end
                            else if (text_byte == aecp_pkg::CH_SAVE)
                                cmd.op = aecp_pkg::OP_SAVE;
                            else if (text_byte == aecp_pkg::CH_REST)
                                cmd.op = aecp_pkg::OP_RESTORE;
                            else if (text_byte == aecp_pkg::CH_QUERY)
                                phase_next = aecp_pkg::PH_SKIP;
                            else if (text_byte == aecp_pkg::CH_UP)
                                cmd.op = aecp_pkg::OP_UP1;
                            else if (text_byte == aecp_pkg::CH_DOWN)
                                cmd.op = aecp_pkg::OP_DOWN1;
                            else if (text_byte == aecp_pkg::CH_RIGHT)
                                cmd.op = aecp_pkg::OP_RIGHT1;
                            else if (text_byte == aecp_pkg::CH_HOME)
                                cmd.op = aecp_pkg::OP_HOME;
                            else if (text_byte == aecp_pkg::CH_ERASE
                                     || text_byte == aecp_pkg::CH_ERASEL)
                            begin
                                if (!status.idx_zero)
                                    cmd.event_code = aecp_pkg::EV_FATAL;
                            end
                            else if (aecp_pkg::is_digit(text_byte))
                            begin
                                cmd.op     = aecp_pkg::OP_DIGIT_FIRST;
                                phase_next = aecp_pkg::PH_INT;
                            end
                            else
                                cmd.event_code = aecp_pkg::EV_FATAL;
                        end
                        aecp_pkg::PH_INT:
                        begin
                            if (aecp_pkg::is_letter(text_byte))
                            begin
                                phase_next = aecp_pkg::PH_GROUND;
                                if (status.idx_full)
                                    cmd.event_code = aecp_pkg::EV_FATAL;
                                else if (text_byte == aecp_pkg::CH_ATTR)
                                begin
                                    cmd.op       = aecp_pkg::OP_SWEEP_BEGIN;
                                    cmd.load_out = 1'b0;
                                    state_next   = aecp_pkg::ST_SWEEP;
                                end
                                else
                                begin
                                    cmd.op = aecp_pkg::OP_DISPATCH;
                                    if (text_byte == aecp_pkg::CH_UP
                                        || text_byte == aecp_pkg::CH_DOWN
                                        || text_byte == aecp_pkg::CH_RIGHT
                                        || text_byte == aecp_pkg::CH_LEFT
                                        || text_byte == aecp_pkg::CH_HOME)
                                        cmd.event_code = aecp_pkg::EV_NONE;
                                    else if (text_byte == aecp_pkg::CH_ERASE)
                                        cmd.event_code = aecp_pkg::EV_CLEAR;
                                    else if (text_byte == aecp_pkg::CH_SETUP
                                             && status.p0_is7)
                                        cmd.event_code = aecp_pkg::EV_NONE;
                                    else
                                        cmd.event_code = aecp_pkg::EV_FATAL;
                                end
                            end
                            else if (text_byte == aecp_pkg::CH_SEMI)
                            begin
                                if (status.idx_full)
                                begin
                                    cmd.event_code = aecp_pkg::EV_FATAL;
                                    phase_next     = aecp_pkg::PH_GROUND;
                                end
                                else
                                begin
                                    cmd.op     = aecp_pkg::OP_STORE;
                                    phase_next = aecp_pkg::PH_CSI;
                                end
                            end
                            else if (aecp_pkg::is_digit(text_byte))
                                cmd.op = aecp_pkg::OP_DIGIT_NEXT;
                            else
                            begin
                                cmd.event_code = aecp_pkg::EV_FATAL;
                                phase_next     = aecp_pkg::PH_GROUND;
                            end
                        end
                        aecp_pkg::PH_SKIP:
                        begin
                            if (text_byte == aecp_pkg::CH_RESET)
                                phase_next = aecp_pkg::PH_GROUND;
                        end
                        default:
                        begin
                            phase_next = aecp_pkg::PH_GROUND;
                            if (text_byte == aecp_pkg::CH_EOF)
                                cmd.event_code = aecp_pkg::EV_EOF;
                            else if (text_byte == aecp_pkg::CH_ESC)
                                phase_next = aecp_pkg::PH_ESC;
                            else if (text_byte == aecp_pkg::CH_CR)
                                cmd.op = aecp_pkg::OP_CR;
                            else if (text_byte == aecp_pkg::CH_LF)
                                cmd.op = aecp_pkg::OP_LF;
                            else
                            begin
                                cmd.op         = aecp_pkg::OP_GLYPH;
                                cmd.event_code = aecp_pkg::EV_GLYPH;
                            end
                        end
                    endcase
                end
            end
            aecp_pkg::ST_SWEEP:
            begin
                cmd.op = aecp_pkg::OP_ATTR;
                if (status.attr_bad)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.event_code = aecp_pkg::EV_FATAL;
                    state_next     = aecp_pkg::ST_RUN;
                end
                else if (status.attr_last)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = aecp_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = aecp_pkg::ST_RUN;
            end
        endcase
    end

    a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == aecp_pkg::ST_SWEEP |-> !in_ready)
        else $error("input taken during attribute sweep");

    a_bad_attr_ends_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aecp_pkg::ST_SWEEP && status.attr_bad) |=> state_reg == aecp_pkg::ST_RUN)
        else $error("sweep not ended by bad attribute");

    a_bad_intro_to_ground: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == aecp_pkg::PH_ESC && text_byte != aecp_pkg::CH_LBRACK)
        |=> phase_reg == aecp_pkg::PH_GROUND)
        else $error("bad introducer did not return to ground");

endmodule

FILE: sv/aecp_datapath.sv
module aecp_datapath
#(
    parameter int PARAM_SLOTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            text_byte,
    input  aecp_pkg::cmd_t        cmd,
    output aecp_pkg::status_t     status,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            event_res,
    output logic [15:0]           write_x,
    output logic [15:0]           write_y,
    output logic [7:0]            glyph,
    output logic [2:0]            fore_colour,
    output logic [2:0]            back_colour,
    output logic                  bold,
    output logic                  soft_clear,
    output logic                  hard_clear
);

    localparam int IDXW = $clog2(PARAM_SLOTS);
    localparam int CNTW = $clog2(PARAM_SLOTS + 1);
    localparam logic [CNTW-1:0] SLOTS_C = CNTW'(PARAM_SLOTS);

    logic [7:0]      lw_reg, sce_dummy;
    logic            sce_reg, hce_reg;
    logic [7:0]      store_reg [PARAM_SLOTS];
    logic [7:0]      store_next [PARAM_SLOTS];
    logic [CNTW-1:0] idx_reg, idx_next;
    logic [IDXW-1:0] sweep_reg, sweep_next;
    logic [7:0]      accum_reg, accum_next;
    logic [15:0]     col_reg, col_next, row_reg, row_next;
    logic [15:0]     scol_reg, scol_next, srow_reg, srow_next;
    logic [2:0]      fg_reg, fg_next, bg_reg, bg_next;
    logic            bold_reg, bold_next, wrap_reg, wrap_next;
    logic            out_valid_reg;

    logic [7:0]      digit;
    logic [7:0]      p0, p1, attr;
    logic [15:0]     p0_cnt, glyph_col, glyph_row;
    logic            do_store;

    assign sce_dummy = 8'd0;
    assign digit     = text_byte - aecp_pkg::CH_ZERO;
    assign p0        = (idx_reg == CNTW'(0)) ? accum_reg : store_reg[0];
    assign p1        = (idx_reg == CNTW'(1)) ? accum_reg : store_reg[1];
    assign p0_cnt    = (p0 == 8'd0) ? 16'd1 : {8'd0, p0};
    assign attr      = store_reg[sweep_reg];

    assign status.idx_full  = (idx_reg == SLOTS_C);
    assign status.idx_zero  = (idx_reg == CNTW'(0));
    assign status.p0_is7    = (p0 == aecp_pkg::WRAP_MODE);
    assign status.attr_bad  = !((attr >= aecp_pkg::SGR_FG_LO && attr <= aecp_pkg::SGR_FG_HI)
                              || (attr >= aecp_pkg::SGR_BG_LO && attr <= aecp_pkg::SGR_BG_HI)
                              || attr == aecp_pkg::SGR_RESET || attr == aecp_pkg::SGR_BOLD
                              || attr == aecp_pkg::SGR_NO_BOLD);
    assign status.attr_last = (CNTW'(sweep_reg) + CNTW'(1) == idx_reg);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign do_store = (cmd.op == aecp_pkg::OP_STORE) || (cmd.op == aecp_pkg::OP_DISPATCH)
                    || (cmd.op == aecp_pkg::OP_SWEEP_BEGIN);

    always_comb
    begin
        if (lw_reg != sce_dummy && wrap_reg && col_reg >= {8'd0, lw_reg})
        begin
            glyph_col = col_reg - {8'd0, lw_reg};
            glyph_row = row_reg + 16'd1;
        end
        else if (lw_reg == sce_dummy && wrap_reg)
        begin
            glyph_col = col_reg;
            glyph_row = row_reg + 16'd1;
        end
        else
        begin
            glyph_col = col_reg;
            glyph_row = row_reg;
        end
    end

    always_comb
    begin
        store_next = store_reg;
        idx_next   = idx_reg;
        sweep_next = sweep_reg;
        accum_next = accum_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        scol_next  = scol_reg;
        srow_next  = srow_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        bold_next  = bold_reg;
        wrap_next  = wrap_reg;
        if (do_store)
        begin
            store_next[idx_reg[IDXW-1:0]] = accum_reg;
            idx_next = idx_reg + CNTW'(1);
        end
        case (cmd.op)
            aecp_pkg::OP_GLYPH:
            begin
                col_next = glyph_col + 16'd1;
                row_next = glyph_row;
            end
            aecp_pkg::OP_CR:
                col_next = 16'd0;
            aecp_pkg::OP_LF:
            begin
                col_next = 16'd0;
                row_next = row_reg + 16'd1;
            end
            aecp_pkg::OP_SAVE:
            begin
                scol_next = col_reg;
                srow_next = row_reg;
            end
            aecp_pkg::OP_RESTORE:
            begin
                col_next = scol_reg;
                row_next = srow_reg;
            end
            aecp_pkg::OP_UP1:
                row_next = row_reg - 16'd1;
            aecp_pkg::OP_DOWN1:
                row_next = row_reg + 16'd1;
            aecp_pkg::OP_RIGHT1:
                col_next = col_reg + 16'd1;
            aecp_pkg::OP_HOME:
            begin
                col_next = 16'd0;
                row_next = 16'd0;
            end
            aecp_pkg::OP_CLEAR_PARAMS:
            begin
                for (int i = 0; i < PARAM_SLOTS; i++)
                    store_next[i] = 8'd0;
                idx_next   = '0;
                accum_next = 8'd0;
            end
            aecp_pkg::OP_SKIP_PARAM:
                idx_next = idx_reg + CNTW'(1);
            aecp_pkg::OP_DIGIT_FIRST:
                accum_next = digit;
            aecp_pkg::OP_DIGIT_NEXT:
                accum_next = 8'(accum_reg * 8'd10) + digit;
            aecp_pkg::OP_STORE:
                accum_next = 8'd0;
            aecp_pkg::OP_DISPATCH:
            begin
                case (text_byte)
                    aecp_pkg::CH_UP:    row_next = row_reg - p0_cnt;
                    aecp_pkg::CH_DOWN:  row_next = row_reg + p0_cnt;
                    aecp_pkg::CH_RIGHT: col_next = col_reg + p0_cnt;
                    aecp_pkg::CH_LEFT:  col_next = col_reg - p0_cnt;
                    aecp_pkg::CH_HOME:
                    begin
                        row_next = (p0 == 8'd0) ? 16'd0 : {8'd0, p0 - 8'd1};
                        col_next = (p1 == 8'd0) ? 16'd0 : {8'd0, p1 - 8'd1};
                    end
                    aecp_pkg::CH_SETUP:
                    begin
                        if (p0 == aecp_pkg::WRAP_MODE)
                            wrap_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            aecp_pkg::OP_SWEEP_BEGIN:
                sweep_next = '0;
            aecp_pkg::OP_ATTR:
            begin
                sweep_next = sweep_reg + IDXW'(1);
                if (attr >= aecp_pkg::SGR_FG_LO && attr <= aecp_pkg::SGR_FG_HI)
                    fg_next = 3'(attr - aecp_pkg::SGR_FG_LO);
                else if (attr >= aecp_pkg::SGR_BG_LO && attr <= aecp_pkg::SGR_BG_HI)
                    bg_next = 3'(attr - aecp_pkg::SGR_BG_LO);
                else if (attr == aecp_pkg::SGR_RESET)
                begin
                    fg_next   = aecp_pkg::FG_RESET;
                    bg_next   = 3'd0;
                    bold_next = 1'b0;
                end
                else if (attr == aecp_pkg::SGR_BOLD)
                    bold_next = 1'b1;
                else if (attr == aecp_pkg::SGR_NO_BOLD)
                    bold_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg    <= aecp_pkg::LINE_WIDTH_RESET;
            sce_reg   <= 1'b0;
            hce_reg   <= 1'b0;
            for (int i = 0; i < PARAM_SLOTS; i++)
                store_reg[i] <= 8'd0;
            idx_reg   <= '0;
            sweep_reg <= '0;
            accum_reg <= 8'd0;
            col_reg   <= 16'd0;
            row_reg   <= 16'd0;
            scol_reg  <= 16'd0;
            srow_reg  <= 16'd0;
            fg_reg    <= aecp_pkg::FG_RESET;
            bg_reg    <= 3'd0;
            bold_reg  <= 1'b0;
            wrap_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    aecp_pkg::CFG_LINE_WIDTH: lw_reg  <= cfg_data;
                    aecp_pkg::CFG_SOFT_CLEAR: sce_reg <= cfg_data[0];
                    aecp_pkg::CFG_HARD_CLEAR: hce_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            store_reg <= store_next;
            idx_reg   <= idx_next;
            sweep_reg <= sweep_next;
            accum_reg <= accum_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            scol_reg  <= scol_next;
            srow_reg  <= srow_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            bold_reg  <= bold_next;
            wrap_reg  <= wrap_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            event_res   <= cmd.event_code;
            write_x     <= 16'd0;
            write_y     <= 16'd0;
            glyph       <= 8'd0;
            fore_colour <= 3'd0;
            back_colour <= 3'd0;
            bold        <= 1'b0;
            soft_clear  <= 1'b0;
            hard_clear  <= 1'b0;
            if (cmd.event_code == aecp_pkg::EV_GLYPH)
            begin
                write_x     <= glyph_col;
                write_y     <= glyph_row;
                glyph       <= text_byte;
                fore_colour <= fg_reg;
                back_colour <= bg_reg;
                bold        <= bold_reg;
            end
            else if (cmd.event_code == aecp_pkg::EV_CLEAR)
            begin
                soft_clear <= sce_reg;
                hard_clear <= hce_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule
